// File: rtl/core/twwf_pkg.sv
// shared constants, types and weight table of the trimmed weighted window filter
`default_nettype none

package twwf_pkg;

	localparam int DATA_W          = 16;   // width of the sample and filtered fields
	localparam int DEF_SAMPLE_BITS = 16;
	localparam int WIN_LEN         = 10;
	localparam int POS_W           = $clog2(WIN_LEN);
	localparam int SCAN_LEN        = 2 * WIN_LEN;
	localparam int SCAN_W          = $clog2(SCAN_LEN);
	localparam int NUM_HI          = 3;    // largest values struck
	localparam int NUM_LO          = NUM_HI + 1;
	localparam int KEEP_CNT        = WIN_LEN - NUM_HI - 1;
	localparam int KEEP_W          = $clog2(KEEP_CNT + 1);
	localparam int WGT_W           = 6;
	localparam int DIVISOR         = 100;
	localparam int REM_W           = $clog2(DIVISOR);
	localparam int ACC_XTRA        = 7;    // 100 * max sample stays below 2^(bits+7)

	typedef struct packed {
		logic clr;
		logic en;
	} rank_ctl_t;

	function automatic logic [WGT_W-1:0] keep_weight(input logic [KEEP_W-1:0] k);
		logic [WGT_W-1:0] w;
		unique case (k)
			3'd0:    w = 6'd3;
			3'd1:    w = 6'd14;
			3'd2:    w = 6'd33;
			3'd3:    w = 6'd33;
			3'd4:    w = 6'd14;
			3'd5:    w = 6'd3;
			default: w = 6'd0;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/twwf_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module twwf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 10
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/twwf_rank.sv
// streaming rank tracker: three largest and four smallest positions, drop mask
`default_nettype none

module twwf_rank
	import twwf_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire rank_ctl_t              ctl,
	input  wire logic [SAMPLE_BITS-1:0] din,
	input  wire logic [POS_W-1:0]       pos,
	output      logic [WIN_LEN-1:0]     drop
);

	logic [SAMPLE_BITS-1:0] hi_val_q [NUM_HI];
	logic [POS_W-1:0]       hi_pos_q [NUM_HI];
	logic [NUM_HI-1:0]      hi_vld_q;
	logic [SAMPLE_BITS-1:0] lo_val_q [NUM_LO];
	logic [POS_W-1:0]       lo_pos_q [NUM_LO];
	logic [NUM_LO-1:0]      lo_vld_q;

	logic [SAMPLE_BITS-1:0] hi_val_n [NUM_HI];
	logic [POS_W-1:0]       hi_pos_n [NUM_HI];
	logic [NUM_HI-1:0]      hi_vld_n;
	logic [NUM_HI-1:0]      hi_ins;
	logic [SAMPLE_BITS-1:0] lo_val_n [NUM_LO];
	logic [POS_W-1:0]       lo_pos_n [NUM_LO];
	logic [NUM_LO-1:0]      lo_vld_n;
	logic [NUM_LO-1:0]      lo_ins;
	logic [WIN_LEN-1:0]     hi_mask;
	logic                   found;

	// strict compares keep the earlier position ahead on ties
	always_comb begin
		for (int j = 0; j < NUM_HI; j++) begin
			hi_ins[j] = !hi_vld_q[j] || (din > hi_val_q[j]);
		end
		hi_val_n[0] = hi_ins[0] ? din : hi_val_q[0];
		hi_pos_n[0] = hi_ins[0] ? pos : hi_pos_q[0];
		hi_vld_n[0] = hi_vld_q[0] | hi_ins[0];
		for (int j = 1; j < NUM_HI; j++) begin
			if (hi_ins[j] && hi_ins[j-1]) begin
				hi_val_n[j] = hi_val_q[j-1];
				hi_pos_n[j] = hi_pos_q[j-1];
				hi_vld_n[j] = hi_vld_q[j-1];
			end else if (hi_ins[j]) begin
				hi_val_n[j] = din;
				hi_pos_n[j] = pos;
				hi_vld_n[j] = 1'b1;
			end else begin
				hi_val_n[j] = hi_val_q[j];
				hi_pos_n[j] = hi_pos_q[j];
				hi_vld_n[j] = hi_vld_q[j];
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NUM_LO; j++) begin
			lo_ins[j] = !lo_vld_q[j] || (din < lo_val_q[j]);
		end
		lo_val_n[0] = lo_ins[0] ? din : lo_val_q[0];
		lo_pos_n[0] = lo_ins[0] ? pos : lo_pos_q[0];
		lo_vld_n[0] = lo_vld_q[0] | lo_ins[0];
		for (int j = 1; j < NUM_LO; j++) begin
			if (lo_ins[j] && lo_ins[j-1]) begin
				lo_val_n[j] = lo_val_q[j-1];
				lo_pos_n[j] = lo_pos_q[j-1];
				lo_vld_n[j] = lo_vld_q[j-1];
			end else if (lo_ins[j]) begin
				lo_val_n[j] = din;
				lo_pos_n[j] = pos;
				lo_vld_n[j] = 1'b1;
			end else begin
				lo_val_n[j] = lo_val_q[j];
				lo_pos_n[j] = lo_pos_q[j];
				lo_vld_n[j] = lo_vld_q[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_vld_q <= '0;
			lo_vld_q <= '0;
		end else if (ctl.clr) begin
			hi_vld_q <= '0;
			lo_vld_q <= '0;
		end else if (ctl.en) begin
			hi_vld_q <= hi_vld_n;
			lo_vld_q <= lo_vld_n;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			hi_val_q <= hi_val_n;
			hi_pos_q <= hi_pos_n;
			lo_val_q <= lo_val_n;
			lo_pos_q <= lo_pos_n;
		end
	end

	// smallest survivor is the first low candidate not already struck as largest
	always_comb begin
		hi_mask = '0;
		for (int j = 0; j < NUM_HI; j++) begin
			hi_mask[hi_pos_q[j]] = 1'b1;
		end
		drop  = hi_mask;
		found = 1'b0;
		for (int j = 0; j < NUM_LO; j++) begin
			if (!found && !hi_mask[lo_pos_q[j]]) begin
				found              = 1'b1;
				drop[lo_pos_q[j]]  = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/twwf_div.sv
// divide by the weight total through a fixed reciprocal, one 16-bit slice a cycle
`default_nettype none

module twwf_div
	import twwf_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [SAMPLE_BITS+ACC_XTRA-1:0] dividend,
	output      logic                            done,
	output      logic [SAMPLE_BITS-1:0]          quot
);

	localparam int ACC_W     = SAMPLE_BITS + ACC_XTRA;
	// reciprocal error times the largest dividend stays below one unit of the shift
	localparam int SHIFT     = ACC_W + REM_W;
	localparam int RCP_W     = ACC_W + 1;
	localparam int SLICE_W   = 16;
	localparam int NUM_SLICE = (RCP_W + SLICE_W - 1) / SLICE_W;
	localparam int RCP_PAD_W = NUM_SLICE * SLICE_W;
	localparam int PROD_W    = ACC_W + RCP_PAD_W;
	localparam int PART_W    = ACC_W + SLICE_W;
	localparam int CNT_W     = $clog2(NUM_SLICE + 1);
	localparam logic [63:0] RCP_64 =
		((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
	localparam logic [RCP_PAD_W-1:0] RCP = RCP_PAD_W'(RCP_64);

	logic [ACC_W-1:0]     dvd_q;
	logic [RCP_PAD_W-1:0] rcp_q;
	logic [PROD_W-1:0]    prod_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [PART_W-1:0]    part;

	// top slice of the reciprocal first, partial products folded in by shifting
	assign part = PART_W'(dvd_q) * PART_W'(rcp_q[RCP_PAD_W-1 -: SLICE_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_SLICE);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= dividend;
			rcp_q  <= RCP;
			prod_q <= '0;
		end else if (busy_q) begin
			prod_q <= (prod_q << SLICE_W) + PROD_W'(part);
			rcp_q  <= rcp_q << SLICE_W;
		end
	end

	assign done = done_q;
	assign quot = prod_q[SHIFT +: SAMPLE_BITS];

endmodule

`default_nettype wire

// File: rtl/core/trimmed_weighted_window_filter_top.sv
// top level of the trimmed weighted window filter: control, window ram, ranking, divide
`default_nettype none

// Trimmed weighted window filter. Each input item carries one distance sample; the block
// keeps the last ten samples in a small circular ram (the first sample after reset fills
// all ten entries), strikes the three largest and then the smallest of the rest (ties go
// to the oldest position), weights the six survivors 3,14,33,33,14,3 in age order and
// returns the sum divided by 100, truncated, as one result item per input item.
// From acceptance to the result register an item passes through two sweeps of the window
// over the single ram read port (one sweep ranks, one sweep sums) and then the divider,
// which multiplies by a fixed reciprocal of 100 one 16-bit slice a cycle; the first item
// after reset fills the ram before its sweeps. Items are taken one at a time; a new
// item is accepted while the previous result still waits on the output side, and a
// finished result holds until the output register is free.

module trimmed_weighted_window_filter_top
	import twwf_pkg::*;
#(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input items
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,   // [15:0] sample
	// result items
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [DATA_W-1:0] m_tdata    // [15:0] filtered
);

	localparam int ACC_W  = SAMPLE_BITS + ACC_XTRA;
	localparam int PROD_W = SAMPLE_BITS + WGT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_SCAN,
		ST_TAIL,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic                   first_q;      // window not yet filled since reset
	logic [POS_W-1:0]       head_q;       // ram address of the oldest sample
	logic [SCAN_W-1:0]      cnt_q;        // fill address, then scan step
	logic [SAMPLE_BITS-1:0] sample_q;     // first sample, held for the fill sweep
	logic [ACC_W-1:0]       acc_q;
	logic [KEEP_W-1:0]      keep_q;       // survivors summed so far
	logic                   m_tvalid_q;
	logic [DATA_W-1:0]      m_tdata_q;

	// read pipeline tags, aligned with the registered ram data
	logic                   rd_vld_s1;
	logic                   rd_sum_s1;    // second sweep: weighting
	logic [POS_W-1:0]       rd_pos_s1;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] s_in;
	logic                   ram_we;
	logic [POS_W-1:0]       ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;
	logic [POS_W-1:0]       ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;
	logic                   scan_sum;
	logic [POS_W-1:0]       scan_pos;
	logic [POS_W:0]         addr_sum;
	logic [POS_W-1:0]       head_inc;
	rank_ctl_t              rank_ctl;
	logic [WIN_LEN-1:0]     drop;
	logic [PROD_W-1:0]      prod;
	logic                   div_start;
	logic                   div_done;
	logic [SAMPLE_BITS-1:0] div_quot;
	logic                   out_load;

	assign accept = s_tvalid && s_tready;
	assign s_in   = SAMPLE_BITS'(s_tdata);   // bits above the sample width are ignored

	// ram write: the fill sweep, or the new sample over the oldest entry
	assign ram_we    = (state_q == ST_FILL) || (accept && !first_q);
	assign ram_waddr = (state_q == ST_FILL) ? cnt_q[POS_W-1:0] : head_q;
	assign ram_wdata = (state_q == ST_FILL) ? sample_q : s_in;
	assign head_inc  = (head_q == POS_W'(WIN_LEN - 1)) ? '0 : head_q + 1'b1;

	// both sweeps walk the window oldest first, starting at the head
	assign scan_sum  = cnt_q >= SCAN_W'(WIN_LEN);
	assign scan_pos  = scan_sum ? POS_W'(cnt_q - SCAN_W'(WIN_LEN)) : cnt_q[POS_W-1:0];
	assign addr_sum  = {1'b0, head_q} + {1'b0, scan_pos};
	assign ram_raddr = (addr_sum >= (POS_W + 1)'(WIN_LEN)) ?
		POS_W'(addr_sum - (POS_W + 1)'(WIN_LEN)) : addr_sum[POS_W-1:0];

	twwf_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WIN_LEN)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// rank state is cleared per item and fed by the first sweep
	assign rank_ctl = '{clr: accept, en: rd_vld_s1 && !rd_sum_s1};

	twwf_rank #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_rank (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (rank_ctl),
		.din   (ram_rdata),
		.pos   (rd_pos_s1),
		.drop  (drop)
	);

	assign prod      = PROD_W'(ram_rdata) * PROD_W'(keep_weight(keep_q));
	assign div_start = (state_q == ST_LOAD);

	twwf_div #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(acc_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// sequencer, window head, fill flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			first_q    <= 1'b1;
			head_q     <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						if (first_q) begin
							state_q <= ST_FILL;
						end else begin
							head_q  <= head_inc;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_FILL: begin
					if (cnt_q == SCAN_W'(WIN_LEN - 1)) begin
						cnt_q   <= '0;
						first_q <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (cnt_q == SCAN_W'(SCAN_LEN - 1)) begin
						state_q <= ST_TAIL;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_TAIL: state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_sum_s1 <= scan_sum;
		rd_pos_s1 <= scan_pos;
		if (accept) begin
			sample_q <= s_in;
			acc_q    <= '0;
			keep_q   <= '0;
		end else if (rd_vld_s1 && rd_sum_s1 && !drop[rd_pos_s1]) begin
			acc_q  <= acc_q + ACC_W'(prod);
			keep_q <= keep_q + 1'b1;
		end
		if (out_load) begin
			m_tdata_q <= DATA_W'(div_quot);
		end
	end

	// exactly six survivors are weighted once both sweeps are through
	a_keep_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (keep_q == KEEP_CNT[KEEP_W-1:0]))
		else $error("survivor count wrong at divide start");

	// four distinct positions are struck out
	a_drop_four: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> ($countones(drop) == NUM_LO))
		else $error("drop mask does not strike four positions");

	// the window is never swept before it has been filled
	a_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !first_q)
		else $error("window swept before fill");

	// the divider signals done only in the divide phase, and not just as it is started
	a_div_seq: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV) && $past(state_q != ST_LOAD))
		else $error("divider done outside divide phase");

endmodule

`default_nettype wire
